### rtl/lfu_pkg.sv
package lfu_pkg;

    typedef struct packed {
        logic        cmd;
        logic [31:0] key;
        logic [31:0] value;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
        logic [31:0] evicted_key;
    } t_out;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic [3:0] CAP_RESET = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_INSERT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TOUCH,
        OP_REMOVE,
        OP_INSERT
    } t_op;

endpackage

### rtl/lfu_cell.sv
module lfu_cell #(
    parameter int CW = 16,
    parameter int RW = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_scan_shift,
    input  logic          i_scan_in_valid,
    input  logic [31:0]   i_scan_in_key,
    input  logic [31:0]   i_scan_in_value,
    input  logic [CW-1:0] i_scan_in_count,
    input  logic [RW-1:0] i_scan_in_rank,
    output logic          o_valid,
    output logic [31:0]   o_key,
    output logic [31:0]   o_value,
    output logic [CW-1:0] o_count,
    output logic [RW-1:0] o_rank,
    input  lfu_pkg::t_op  i_op,
    input  logic          i_sel,
    input  logic [RW-1:0] i_ref_rank,
    input  logic [31:0]   i_new_key,
    input  logic [31:0]   i_new_value,
    input  logic          i_write_value
);

    logic          r_valid;
    logic [31:0]   r_key;
    logic [31:0]   r_value;
    logic [CW-1:0] r_count;
    logic [RW-1:0] r_rank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_scan_shift) begin
            r_valid <= i_scan_in_valid;
        end else if (i_op == lfu_pkg::OP_REMOVE && i_sel) begin
            r_valid <= 1'b0;
        end else if (i_op == lfu_pkg::OP_INSERT && i_sel) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan_shift) begin
            r_key   <= i_scan_in_key;
            r_value <= i_scan_in_value;
            r_count <= i_scan_in_count;
            r_rank  <= i_scan_in_rank;
        end else begin
            case (i_op)
                lfu_pkg::OP_TOUCH: begin
                    if (i_sel) begin
                        r_rank <= '0;
                        if (r_count != {CW{1'b1}}) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_write_value) begin
                            r_value <= i_new_value;
                        end
                    end else if (r_valid && r_rank < i_ref_rank) begin
                        r_rank <= r_rank + 1'b1;
                    end
                end
                lfu_pkg::OP_REMOVE: begin
                    if (!i_sel && r_valid && r_rank > i_ref_rank) begin
                        r_rank <= r_rank - 1'b1;
                    end
                end
                lfu_pkg::OP_INSERT: begin
                    if (i_sel) begin
                        r_key   <= i_new_key;
                        r_value <= i_new_value;
                        r_count <= {{(CW-1){1'b0}}, 1'b1};
                        r_rank  <= '0;
                    end else if (r_valid) begin
                        r_rank <= r_rank + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_count = r_count;
    assign o_rank  = r_rank;

endmodule

### rtl/lfu_cache_lru_tiebreak.sv
// LFU cache with least-recently-used tie-break.
// The input channel (i_in_valid, o_in_stall, i_in_data) carries a get or put
// of a key and value. The output channel (o_out_valid, i_out_stall,
// o_out_data) returns exactly one result for each input transfer.
// The entries sit in a ring of cells. Each item rotates the ring once,
// comparing the cell at the head with the key and tracking the eviction
// candidate and the first free slot by position. The ST_UPDATE state then
// applies the touch or removal, and ST_INSERT the insertion, to all cells
// at once. The result is registered in ST_UPDATE and offered in ST_DONE;
// a put that inserts an entry passes through ST_INSERT first.
// One item is in work at a time; the next is taken once the result has
// been transferred out.
// While the receiver stalls, the result is held and no new item is taken.
// Reset clears all valid bits, the occupancy and the state machine, and
// sets the capacity register r_cap to 8. Configuration is written through the APB port.
module lfu_cache_lru_tiebreak #(
    parameter int CAPACITY    = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lfu_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lfu_pkg::t_out o_out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int CW = COUNT_WIDTH;

    logic [3:0]       r_cap;
    lfu_pkg::t_state  r_state, n_state;
    lfu_pkg::t_in     r_req;
    lfu_pkg::t_out    r_res, n_res;
    logic [IW-1:0]    r_cnt, n_cnt;
    logic [IW-1:0]    r_occ, n_occ;
    logic             r_found, n_found;
    logic [RW-1:0]    r_hit_idx, n_hit_idx;
    logic [31:0]      r_hit_val, n_hit_val;
    logic [RW-1:0]    r_hit_rank, n_hit_rank;
    logic             r_vic_ok, n_vic_ok;
    logic [RW-1:0]    r_vic_idx, n_vic_idx;
    logic [31:0]      r_vic_key, n_vic_key;
    logic [CW-1:0]    r_vic_cnt, n_vic_cnt;
    logic [RW-1:0]    r_vic_rank, n_vic_rank;
    logic             r_free_ok, n_free_ok;
    logic [RW-1:0]    r_free_idx, n_free_idx;

    logic             scan_shift;
    lfu_pkg::t_op     op;
    logic [RW-1:0]    op_idx;
    logic [RW-1:0]    ref_rank;
    logic [IW-1:0]    cap_eff;
    logic             cfg_wr;

    logic          c_valid [CAPACITY];
    logic [31:0]   c_key   [CAPACITY];
    logic [31:0]   c_value [CAPACITY];
    logic [CW-1:0] c_count [CAPACITY];
    logic [RW-1:0] c_rank  [CAPACITY];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr == 2'd0) ? {28'd0, r_cap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lfu_pkg::CAP_RESET;
        end else if (cfg_wr && paddr == 2'd0) begin
            r_cap <= pwdata[3:0];
        end
    end

    assign cap_eff = ({28'd0, r_cap} > 32'(CAPACITY)) ? IW'(CAPACITY) : IW'(r_cap);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int NX = (g + 1) % CAPACITY;
        lfu_cell #(.CW(CW), .RW(RW)) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_scan_shift   (scan_shift),
            .i_scan_in_valid(c_valid[NX]),
            .i_scan_in_key  (c_key[NX]),
            .i_scan_in_value(c_value[NX]),
            .i_scan_in_count(c_count[NX]),
            .i_scan_in_rank (c_rank[NX]),
            .o_valid        (c_valid[g]),
            .o_key          (c_key[g]),
            .o_value        (c_value[g]),
            .o_count        (c_count[g]),
            .o_rank         (c_rank[g]),
            .i_op           (op),
            .i_sel          (op_idx == RW'(g)),
            .i_ref_rank     (ref_rank),
            .i_new_key      (r_req.key),
            .i_new_value    (r_req.value),
            .i_write_value  (r_req.cmd == lfu_pkg::CMD_PUT)
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfu_pkg::ST_IDLE;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lfu_pkg::ST_IDLE && i_in_valid) begin
            r_req <= i_in_data;
        end
        r_res      <= n_res;
        r_cnt      <= n_cnt;
        r_found    <= n_found;
        r_hit_idx  <= n_hit_idx;
        r_hit_val  <= n_hit_val;
        r_hit_rank <= n_hit_rank;
        r_vic_ok   <= n_vic_ok;
        r_vic_idx  <= n_vic_idx;
        r_vic_key  <= n_vic_key;
        r_vic_cnt  <= n_vic_cnt;
        r_vic_rank <= n_vic_rank;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
    end

    always_comb begin
        n_state    = r_state;
        n_res      = r_res;
        n_cnt      = r_cnt;
        n_occ      = r_occ;
        n_found    = r_found;
        n_hit_idx  = r_hit_idx;
        n_hit_val  = r_hit_val;
        n_hit_rank = r_hit_rank;
        n_vic_ok   = r_vic_ok;
        n_vic_idx  = r_vic_idx;
        n_vic_key  = r_vic_key;
        n_vic_cnt  = r_vic_cnt;
        n_vic_rank = r_vic_rank;
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        scan_shift = 1'b0;
        op         = lfu_pkg::OP_NONE;
        op_idx     = '0;
        ref_rank   = '0;
        case (r_state)
            lfu_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state   = lfu_pkg::ST_SCAN;
                    n_cnt     = '0;
                    n_found   = 1'b0;
                    n_vic_ok  = 1'b0;
                    n_free_ok = 1'b0;
                end
            end
            lfu_pkg::ST_SCAN: begin
                scan_shift = 1'b1;
                if (c_valid[0]) begin
                    if (!r_found && c_key[0] == r_req.key) begin
                        n_found    = 1'b1;
                        n_hit_idx  = r_cnt[RW-1:0];
                        n_hit_val  = c_value[0];
                        n_hit_rank = c_rank[0];
                    end
                    if (!r_vic_ok || c_count[0] < r_vic_cnt ||
                        (c_count[0] == r_vic_cnt && c_rank[0] > r_vic_rank)) begin
                        n_vic_ok   = 1'b1;
                        n_vic_idx  = r_cnt[RW-1:0];
                        n_vic_key  = c_key[0];
                        n_vic_cnt  = c_count[0];
                        n_vic_rank = c_rank[0];
                    end
                end else if (!r_free_ok) begin
                    n_free_ok  = 1'b1;
                    n_free_idx = r_cnt[RW-1:0];
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == IW'(CAPACITY - 1)) begin
                    n_state = lfu_pkg::ST_UPDATE;
                end
            end
            lfu_pkg::ST_UPDATE: begin
                n_res   = '0;
                n_state = lfu_pkg::ST_DONE;
                if (r_req.cmd == lfu_pkg::CMD_GET || cap_eff != '0) begin
                    if (r_found) begin
                        op              = lfu_pkg::OP_TOUCH;
                        op_idx          = r_hit_idx;
                        ref_rank        = r_hit_rank;
                        n_res.hit       = 1'b1;
                        n_res.read_value = (r_req.cmd == lfu_pkg::CMD_GET) ? r_hit_val : '0;
                    end else if (r_req.cmd == lfu_pkg::CMD_PUT) begin
                        n_state = lfu_pkg::ST_INSERT;
                        if (r_occ >= cap_eff && r_vic_ok) begin
                            op                = lfu_pkg::OP_REMOVE;
                            op_idx            = r_vic_idx;
                            ref_rank          = r_vic_rank;
                            n_res.evicted     = 1'b1;
                            n_res.evicted_key = r_vic_key;
                            n_free_ok         = 1'b1;
                            n_free_idx        = r_vic_idx;
                            n_occ             = r_occ - 1'b1;
                        end
                    end
                end
            end
            lfu_pkg::ST_INSERT: begin
                n_state = lfu_pkg::ST_DONE;
                if (r_free_ok) begin
                    op     = lfu_pkg::OP_INSERT;
                    op_idx = r_free_idx;
                    n_occ  = r_occ + 1'b1;
                end
            end
            lfu_pkg::ST_DONE: begin
                if (!i_out_stall) begin
                    n_state = lfu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != lfu_pkg::ST_IDLE);
    assign o_out_valid = (r_state == lfu_pkg::ST_DONE);
    assign o_out_data  = r_res;

endmodule

### rtl/lfu_checker.sv
module lfu_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input lfu_pkg::t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_busy_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !o_out_valid && o_in_stall)
        else $error("result too early after input transfer");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.hit && o_out_data.evicted))
        else $error("hit and eviction together");

    a_ev_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.evicted |-> o_out_data.evicted_key == 32'd0)
        else $error("evicted key without eviction");

endmodule

bind lfu_cache_lru_tiebreak lfu_checker u_lfu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);

### tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 8;
    localparam int CNT_W = 16;
    localparam logic [1:0] ADDR_CAPACITY = 2'd0;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    lfu_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_stall;
    lfu_pkg::t_out o_out_data;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [1:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    lfu_cache_lru_tiebreak u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Predictor state of the cache.
    logic             slot_valid [NSLOT];
    logic [31:0]      slot_key   [NSLOT];
    logic [31:0]      slot_value [NSLOT];
    logic [CNT_W-1:0] slot_count [NSLOT];
    int unsigned      slot_rank  [NSLOT];
    int unsigned      fill;
    logic [3:0]       cap_reg;

    lfu_pkg::t_in  pending_ops[$];
    lfu_pkg::t_out expected_results[$];
    int   errors;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_cycles;
    logic in_fire;

    function automatic int find_slot(logic [31:0] k);
        for (int i = 0; i < NSLOT; i++)
            if (slot_valid[i] && slot_key[i] == k) return i;
        return -1;
    endfunction

    function automatic void touch(int s);
        for (int i = 0; i < NSLOT; i++)
            if (slot_valid[i] && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
        slot_rank[s] = 0;
        if (slot_count[s] != '1) slot_count[s]++;
    endfunction

    function automatic lfu_pkg::t_out predict_lookup(lfu_pkg::t_in op);
        lfu_pkg::t_out r;
        int s;
        int vic;
        int unsigned cap;
        r = '0;
        cap = (cap_reg > NSLOT) ? NSLOT : cap_reg;
        if (op.cmd == lfu_pkg::CMD_GET) begin
            s = find_slot(op.key);
            if (s >= 0) begin
                r.hit = 1'b1;
                r.read_value = slot_value[s];
                touch(s);
            end
        end else if (cap != 0) begin
            s = find_slot(op.key);
            if (s >= 0) begin
                r.hit = 1'b1;
                slot_value[s] = op.value;
                touch(s);
            end else begin
                if (fill >= cap) begin
                    vic = -1;
                    for (int i = 0; i < NSLOT; i++) begin
                        if (!slot_valid[i]) continue;
                        if (vic < 0 || slot_count[i] < slot_count[vic] ||
                            (slot_count[i] == slot_count[vic] &&
                             slot_rank[i] > slot_rank[vic]))
                            vic = i;
                    end
                    if (vic >= 0) begin
                        r.evicted = 1'b1;
                        r.evicted_key = slot_key[vic];
                        slot_valid[vic] = 1'b0;
                        for (int i = 0; i < NSLOT; i++)
                            if (slot_valid[i] && slot_rank[i] > slot_rank[vic])
                                slot_rank[i]--;
                        if (fill > 0) fill--;
                    end
                end
                s = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (!slot_valid[i] && s < 0) s = i;
                if (s >= 0) begin
                    for (int i = 0; i < NSLOT; i++)
                        if (slot_valid[i]) slot_rank[i]++;
                    slot_valid[s] = 1'b1;
                    slot_key[s] = op.key;
                    slot_value[s] = op.value;
                    slot_count[s] = CNT_W'(1);
                    slot_rank[s] = 0;
                    fill++;
                end
            end
        end
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Driver: offers the oldest pending operation.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (pending_ops.size() > 0 &&
                $urandom_range(99, 0) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_ops.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
    end

    // Monitor: predicts at input transfer and checks at output transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            expected_results.push_back(predict_lookup(i_in_data));
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                lfu_pkg::t_out e;
                e = expected_results.pop_front();
                if (o_out_data.hit !== e.hit) begin
                    $error("hit exp %0h got %0h", e.hit, o_out_data.hit);
                    errors++;
                end
                if (o_out_data.read_value !== e.read_value) begin
                    $error("read_value exp %0h got %0h", e.read_value,
                           o_out_data.read_value);
                    errors++;
                end
                if (o_out_data.evicted !== e.evicted) begin
                    $error("evicted exp %0h got %0h", e.evicted, o_out_data.evicted);
                    errors++;
                end
                if (o_out_data.evicted_key !== e.evicted_key) begin
                    $error("evicted_key exp %0h got %0h", e.evicted_key,
                           o_out_data.evicted_key);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_ops.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [3:0] cap);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_CAPACITY;
        pwdata <= {28'd0, cap};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cap_reg = cap;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic void queue_op(logic c, logic [31:0] k, logic [31:0] v);
        lfu_pkg::t_in op;
        op.cmd = c;
        op.key = k;
        op.value = v;
        pending_ops.push_back(op);
    endfunction

    // Keys mostly come from a small pool so that hits and evictions are common.
    task automatic queue_random(int n, int pool);
        logic [31:0] k;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9, 0) == 0) k = $urandom;
            else k = 32'h8000_0000 ^ $urandom_range(pool - 1, 0);
            queue_op(1'($urandom_range(1, 0)), k, $urandom);
        end
    endtask

    initial begin
        int phase_idle[4] = '{0, 67, 0, 36};
        int phase_stall[4] = '{0, 0, 67, 36};
        logic [3:0] caps[6] = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd0, 4'd5};
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        in_fire = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cap_reg = lfu_pkg::CAP_RESET;
        fill = 0;
        for (int i = 0; i < NSLOT; i++) begin
            slot_valid[i] = 1'b0;
            slot_key[i] = '0;
            slot_value[i] = '0;
            slot_count[i] = '0;
            slot_rank[i] = 0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes of keys and values, get miss, put hit, fill and evict.
        queue_op(lfu_pkg::CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_op(lfu_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_op(lfu_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_op(lfu_pkg::CMD_PUT, 32'h0, 32'hFFFF_FFFF);
        queue_op(lfu_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0);
        queue_op(lfu_pkg::CMD_PUT, 32'h8000_0000, 32'h0);
        queue_op(lfu_pkg::CMD_GET, 32'h8000_0000, 32'h0);
        for (int i = 1; i <= 7; i++) queue_op(lfu_pkg::CMD_PUT, 32'hFFFF_FFF0 + i, i);
        queue_op(lfu_pkg::CMD_GET, 32'hFFFF_FFF1, 32'h0);
        queue_op(lfu_pkg::CMD_PUT, 32'h1234_5678, 32'hA5A5_A5A5);
        queue_op(lfu_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering.
        queue_random(40, 12);
        hold_cycles = 300;
        wait_drained();

        // Capacity zero, then lowered below occupancy.
        write_capacity(4'd0);
        queue_op(lfu_pkg::CMD_PUT, 32'hDEAD_BEEF, 32'h1);
        queue_op(lfu_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0);
        wait_drained();
        write_capacity(4'd2);
        queue_op(lfu_pkg::CMD_PUT, 32'h5555_AAAA, 32'h2);
        queue_op(lfu_pkg::CMD_PUT, 32'hAAAA_5555, 32'h3);
        wait_drained();

        // Repeated hits on one key.
        write_capacity(4'd8);
        queue_op(lfu_pkg::CMD_PUT, 32'h0000_0042, 32'h42);
        for (int i = 0; i < 20; i++) queue_op(lfu_pkg::CMD_GET, 32'h0000_0042, 32'h0);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            send_idle_pct = phase_idle[p % 4];
            recv_stall_pct = phase_stall[p % 4];
            write_capacity(caps[p]);
            queue_random(215, 4 + 3 * p);
            wait_drained();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
